/* rtl/dws_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dws_pkg: shared types and constants for the delay window search block
// Tap width, configuration register indexes and the structs that travel
// between the tracker and the top level.
// ----------------------------------------------------------------------------
package dws_pkg;

    localparam int TAP_BITS = 6;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = TAP_BITS;

    typedef logic [TAP_BITS-1:0] tap_t;

    // A window wider than this many taps is considered comfortable.
    localparam logic signed [TAP_BITS:0] WIDE_LIMIT = (TAP_BITS + 1)'(3);
    localparam tap_t DEFAULT_DELAY_RESET = TAP_BITS'(12);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_SEARCH_MODE       = 2'd0,
        REG_DEFAULT_DELAY     = 2'd1,
        REG_ZERO_USES_DEFAULT = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        MODE_WIDEST = 1'b0,
        MODE_FIRST  = 1'b1
    } search_mode_t;

    typedef struct packed {
        search_mode_t search_mode;
        tap_t         default_delay;
        logic         zero_uses_default;
    } cfg_t;

    typedef struct packed {
        tap_t tap;
        logic passed;
        logic sweep_end;
    } probe_t;

    typedef struct packed {
        tap_t chosen_tap;
        tap_t window_low;
        tap_t window_high;
        logic window_found;
        logic window_wide;
    } result_t;

endpackage

/* rtl/dws_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dws_if: item channels of the delay window search block
// One channel carries probe items in, the other carries sweep results out.
// ----------------------------------------------------------------------------
interface dws_probe_if
    import dws_pkg::*;
();
    logic valid;
    logic ready;
    tap_t tap;
    logic passed;
    logic sweep_end;

    modport source (output valid, output tap, output passed, output sweep_end, input ready);
    modport sink (input valid, input tap, input passed, input sweep_end, output ready);
endinterface

interface dws_result_if
    import dws_pkg::*;
();
    logic valid;
    logic ready;
    tap_t chosen_tap;
    tap_t window_low;
    tap_t window_high;
    logic window_found;
    logic window_wide;

    modport source (output valid, output chosen_tap, output window_low, output window_high,
                    output window_found, output window_wide, input ready);
    modport sink (input valid, input chosen_tap, input window_low, input window_high,
                  input window_found, input window_wide, output ready);
endinterface

/* rtl/dws_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dws_tracker: passing-run tracker and window selection
// Holds the open run and the kept window, updates them for one probe per
// enabled cycle and forms the sweep result on the last probe.
// ----------------------------------------------------------------------------
module dws_tracker
    import dws_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  probe_t  probe,
    input  cfg_t    cfg,
    output result_t result
);

    tap_t run_start_reg, run_start_next;
    tap_t run_stop_reg, run_stop_next;
    logic run_open_reg, run_open_next;
    tap_t best_start_reg, best_start_next;
    tap_t best_stop_reg, best_stop_next;
    logic best_valid_reg, best_valid_next;
    logic first_closed_reg, first_closed_next;

    logic                      skip;
    logic                      ro1;
    tap_t                      rs1;
    tap_t                      rp1;
    logic                      close_now;
    logic signed [TAP_BITS:0]  run_width;
    logic signed [TAP_BITS:0]  best_width;
    logic signed [TAP_BITS:0]  kept_width;
    tap_t                      bs2;
    tap_t                      bp2;
    logic                      bv2;
    logic                      fc2;
    logic [TAP_BITS:0]         tap_sum;
    tap_t                      midpoint;

    always_comb
    begin
        // In first mode, nothing moves once the first run has closed.
        skip = (cfg.search_mode == MODE_FIRST) && first_closed_reg;

        ro1 = run_open_reg;
        rs1 = run_start_reg;
        rp1 = run_stop_reg;
        if (!skip && probe.passed)
        begin
            ro1 = 1'b1;
            rs1 = run_open_reg ? run_start_reg : probe.tap;
            rp1 = probe.tap;
        end

        // A failing probe or the end of the sweep closes an open run.
        close_now = ro1 && (probe.sweep_end || (!skip && !probe.passed));

        run_width  = $signed({1'b0, rp1}) - $signed({1'b0, rs1});
        best_width = best_valid_reg
                   ? $signed({1'b0, best_stop_reg}) - $signed({1'b0, best_start_reg})
                   : '0;

        bs2 = best_start_reg;
        bp2 = best_stop_reg;
        bv2 = best_valid_reg;
        fc2 = first_closed_reg;
        if (close_now)
        begin
            if (cfg.search_mode == MODE_FIRST)
            begin
                if (!first_closed_reg)
                begin
                    bs2 = rs1;
                    bp2 = rp1;
                    bv2 = 1'b1;
                    fc2 = 1'b1;
                end
            end
            else if (run_width > best_width)
            begin
                bs2 = rs1;
                bp2 = rp1;
                bv2 = 1'b1;
            end
        end

        kept_width = $signed({1'b0, bp2}) - $signed({1'b0, bs2});
        tap_sum    = {1'b0, bs2} + {1'b0, bp2};
        midpoint   = tap_sum[TAP_BITS:1];

        if (bv2)
        begin
            result.window_low   = bs2;
            result.window_high  = bp2;
            result.window_found = 1'b1;
            result.window_wide  = kept_width > WIDE_LIMIT;
            result.chosen_tap   = (midpoint == '0 && cfg.zero_uses_default)
                                ? cfg.default_delay : midpoint;
        end
        else
        begin
            result.window_low   = '0;
            result.window_high  = '0;
            result.window_found = 1'b0;
            result.window_wide  = 1'b0;
            result.chosen_tap   = cfg.default_delay;
        end

        run_start_next    = run_start_reg;
        run_stop_next     = run_stop_reg;
        run_open_next     = run_open_reg;
        best_start_next   = best_start_reg;
        best_stop_next    = best_stop_reg;
        best_valid_next   = best_valid_reg;
        first_closed_next = first_closed_reg;
        if (en)
        begin
            if (probe.sweep_end)
            begin
                // The sweep is reported; start the next one from scratch.
                run_start_next    = '0;
                run_stop_next     = '0;
                run_open_next     = 1'b0;
                best_start_next   = '0;
                best_stop_next    = '0;
                best_valid_next   = 1'b0;
                first_closed_next = 1'b0;
            end
            else
            begin
                run_start_next    = rs1;
                run_stop_next     = rp1;
                run_open_next     = ro1 && !close_now;
                best_start_next   = bs2;
                best_stop_next    = bp2;
                best_valid_next   = bv2;
                first_closed_next = fc2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_start_reg    <= '0;
            run_stop_reg     <= '0;
            run_open_reg     <= 1'b0;
            best_start_reg   <= '0;
            best_stop_reg    <= '0;
            best_valid_reg   <= 1'b0;
            first_closed_reg <= 1'b0;
        end
        else
        begin
            run_start_reg    <= run_start_next;
            run_stop_reg     <= run_stop_next;
            run_open_reg     <= run_open_next;
            best_start_reg   <= best_start_next;
            best_stop_reg    <= best_stop_next;
            best_valid_reg   <= best_valid_next;
            first_closed_reg <= first_closed_next;
        end
    end

    a_sweep_clears: assert property (@(posedge clk) disable iff (!rst_n)
        en && probe.sweep_end |=> !run_open_reg && !best_valid_reg && !first_closed_reg)
        else $error("tracking state not cleared after sweep end");

    a_empty_best_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !best_valid_reg |-> best_start_reg == '0 && best_stop_reg == '0)
        else $error("empty kept window does not read as zero");

    a_first_has_best: assert property (@(posedge clk) disable iff (!rst_n)
        first_closed_reg |-> best_valid_reg)
        else $error("first run closed without a kept window");

    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(best_valid_reg) && $stable(run_open_reg))
        else $error("tracking state moved without a probe");

endmodule

/* rtl/delay_window_search.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delay_window_search: receive-delay calibration window tracker
// Tracks runs of passing delay taps over a sweep and reports the kept
// window, its midpoint tap and a width flag on the last probe.
// ----------------------------------------------------------------------------
// The block takes one probe item per clock cycle, unless a sweep end stalls
// as described below, and sends one result item per sweep, offered from the
// output register once the sweep-end probe leaves the input register.
// Each probe is registered at the input, then the run tracker updates its
// few state registers and, on the sweep end, loads the output register; the
// whole update is one short compare-and-select path between those two
// registers. Because the output register is separate, probes keep flowing
// while a result waits to be taken; only a second sweep end stalls behind an
// untaken result. Configuration registers (search mode, default delay and
// zero replacement) are written through cfg_we, cfg_index and cfg_data and
// should be changed only while no probe item is held in the input register;
// a change between two probes of a sweep applies to the probes after it. In
// widest mode the kept window is the widest run of passing taps (strictly
// wider replaces); in first mode it is the first run. A run still open at
// the sweep end is closed and counts. With no window the chosen tap is the
// default delay.
// ----------------------------------------------------------------------------
module delay_window_search
    import dws_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    dws_probe_if.sink                probe,
    dws_result_if.source             result,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    cfg_t    cfg_reg, cfg_next;
    logic    in_valid_reg, in_valid_next;
    probe_t  in_item_reg, in_item_next;
    logic    out_valid_reg, out_valid_next;
    result_t out_item_reg, out_item_next;
    result_t sweep_result;
    logic    advance;

    // The registered probe moves into the tracker unless it ends a sweep
    // and the previous result is still waiting at the output.
    assign advance = in_valid_reg
                   && (!in_item_reg.sweep_end || !out_valid_reg || result.ready);
    assign probe.ready = !in_valid_reg || advance;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SEARCH_MODE:       cfg_next.search_mode = search_mode_t'(cfg_data[0]);
                REG_DEFAULT_DELAY:     cfg_next.default_delay = cfg_data[TAP_BITS-1:0];
                REG_ZERO_USES_DEFAULT: cfg_next.zero_uses_default = cfg_data[0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_item_next  = in_item_reg;
        if (probe.ready)
        begin
            in_valid_next = probe.valid;
            in_item_next  = '{tap: probe.tap, passed: probe.passed,
                              sweep_end: probe.sweep_end};
        end

        out_valid_next = out_valid_reg && !result.ready;
        out_item_next  = out_item_reg;
        if (advance && in_item_reg.sweep_end)
        begin
            out_valid_next = 1'b1;
            out_item_next  = sweep_result;
        end
    end

    dws_tracker u_tracker (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (advance),
        .probe  (in_item_reg),
        .cfg    (cfg_reg),
        .result (sweep_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= '{search_mode: MODE_WIDEST,
                               default_delay: DEFAULT_DELAY_RESET,
                               zero_uses_default: 1'b0};
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        in_item_reg  <= in_item_next;
        out_item_reg <= out_item_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.chosen_tap   = out_item_reg.chosen_tap;
    assign result.window_low   = out_item_reg.window_low;
    assign result.window_high  = out_item_reg.window_high;
    assign result.window_found = out_item_reg.window_found;
    assign result.window_wide  = out_item_reg.window_wide;

    a_no_window_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_item_reg.window_found
        |-> out_item_reg.window_low == '0 && out_item_reg.window_high == '0
            && !out_item_reg.window_wide)
        else $error("result without a window carries window data");

    a_sweep_end_loads: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_item_reg.sweep_end |=> out_valid_reg)
        else $error("sweep end did not produce a result");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result.ready |-> !(advance && in_item_reg.sweep_end))
        else $error("pending result overwritten");

endmodule

/* tb/dws_window_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dws_window_checker: result predictor and comparator for delay_window_search
// Watches the probe and result channels and the register write port. Keeps
// its own copy of the run tracker and the registers, queues the window each
// sweep end should produce, and compares every result item field by field.
// ----------------------------------------------------------------------------
module dws_window_checker
    import dws_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    dws_probe_if                     probe,
    dws_result_if                    result,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    output int                       errors,
    output int                       pending,
    output int                       results_seen
);

    localparam int PRINT_CAP = 40;

    cfg_t    cfg;
    tap_t    run_start;
    tap_t    run_stop;
    logic    run_open;
    tap_t    best_start;
    tap_t    best_stop;
    logic    best_valid;
    logic    first_closed;
    result_t predicted_windows[$];

    task automatic report_mismatch(string what, int got, int want);
        if (errors < PRINT_CAP)
            $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    task automatic clear_tracker();
        run_start    = '0;
        run_stop     = '0;
        run_open     = 1'b0;
        best_start   = '0;
        best_stop    = '0;
        best_valid   = 1'b0;
        first_closed = 1'b0;
    endtask

    // Close the open run under the mode in force right now.
    task automatic close_open_run();
        int run_width;
        int best_width;
        if (run_open) begin
            run_open = 1'b0;
            if (cfg.search_mode == MODE_FIRST) begin
                if (!first_closed) begin
                    best_start   = run_start;
                    best_stop    = run_stop;
                    best_valid   = 1'b1;
                    first_closed = 1'b1;
                end
            end
            else begin
                run_width  = int'(run_stop) - int'(run_start);
                best_width = best_valid ? int'(best_stop) - int'(best_start) : 0;
                if (run_width > best_width) begin
                    best_start = run_start;
                    best_stop  = run_stop;
                    best_valid = 1'b1;
                end
            end
        end
    endtask

    task automatic track_probe(probe_t p);
        result_t             win;
        logic [TAP_BITS:0]   tap_sum;
        if (!(cfg.search_mode == MODE_FIRST && first_closed)) begin
            if (p.passed) begin
                if (!run_open) begin
                    run_start = p.tap;
                    run_open  = 1'b1;
                end
                run_stop = p.tap;
            end
            else
                close_open_run();
        end
        if (p.sweep_end) begin
            close_open_run();
            if (best_valid) begin
                tap_sum = {1'b0, best_start} + {1'b0, best_stop};
                win.chosen_tap = tap_sum[TAP_BITS:1];
                if (win.chosen_tap == '0 && cfg.zero_uses_default)
                    win.chosen_tap = cfg.default_delay;
                win.window_low   = best_start;
                win.window_high  = best_stop;
                win.window_found = 1'b1;
                win.window_wide  = (int'(best_stop) - int'(best_start)) > int'(WIDE_LIMIT);
            end
            else begin
                win.chosen_tap   = cfg.default_delay;
                win.window_low   = '0;
                win.window_high  = '0;
                win.window_found = 1'b0;
                win.window_wide  = 1'b0;
            end
            predicted_windows.push_back(win);
            clear_tracker();
        end
    endtask

    task automatic compare_result();
        result_t want;
        results_seen++;
        if (predicted_windows.size() == 0) begin
            report_mismatch("result item with nothing expected, chosen_tap",
                            result.chosen_tap, 0);
        end
        else begin
            want = predicted_windows.pop_front();
            if (result.chosen_tap !== want.chosen_tap)
                report_mismatch("chosen_tap", result.chosen_tap, want.chosen_tap);
            if (result.window_low !== want.window_low)
                report_mismatch("window_low", result.window_low, want.window_low);
            if (result.window_high !== want.window_high)
                report_mismatch("window_high", result.window_high, want.window_high);
            if (result.window_found !== want.window_found)
                report_mismatch("window_found", result.window_found, want.window_found);
            if (result.window_wide !== want.window_wide)
                report_mismatch("window_wide", result.window_wide, want.window_wide);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        probe_t p;
        if (!rst_n) begin
            cfg.search_mode       = MODE_WIDEST;
            cfg.default_delay     = DEFAULT_DELAY_RESET;
            cfg.zero_uses_default = 1'b0;
            clear_tracker();
            predicted_windows.delete();
            errors       = 0;
            pending      = 0;
            results_seen = 0;
        end
        else begin
            if (result.valid && result.ready)
                compare_result();
            if (probe.valid && probe.ready) begin
                p.tap       = probe.tap;
                p.passed    = probe.passed;
                p.sweep_end = probe.sweep_end;
                track_probe(p);
            end
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_index))
                    REG_SEARCH_MODE:       cfg.search_mode = search_mode_t'(cfg_data[0]);
                    REG_DEFAULT_DELAY:     cfg.default_delay = cfg_data;
                    REG_ZERO_USES_DEFAULT: cfg.zero_uses_default = cfg_data[0];
                    default: ;
                endcase
            end
            pending = predicted_windows.size();
        end
    end

endmodule

/* tb/tb_delay_window_search.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_delay_window_search: testbench top for the delay window search block
// Drives probe sweeps and register settings into the block, throttles the
// result side, and leaves prediction and comparison to the window checker.
// ----------------------------------------------------------------------------
module tb_delay_window_search;
    import dws_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 7;
    // The sweep end passes the input and output registers before its result is
    // offered; settling also covers a held input probe that makes no result.
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 650;
    localparam int PHASE_ITEMS   = 60;
    localparam int LIMIT_CYCLES  = 200000;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    // Throttling controls, changed by the stimulus between phases.
    bit probe_gaps;
    bit result_gaps;
    bit hold_results;

    int probes_sent;
    int sweeps_sent;
    int settings_used;
    int mismatches;
    int windows_pending;
    int results_seen;

    dws_probe_if  probe_ch ();
    dws_result_if result_ch ();

    delay_window_search dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .probe     (probe_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dws_window_checker u_window_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .probe        (probe_ch),
        .result       (result_ch),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .errors       (mismatches),
        .pending      (windows_pending),
        .results_seen (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Hard stop in case the block hangs or drops a result.
    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("delay_window_search: mismatch");
        $finish;
    end

    // Result side. Ready drops in about one cycle out of seven while gaps are
    // enabled. When a hold is requested, ready stays low for a long stretch
    // counted here, so the block's output register fills and a second sweep
    // end backs up into the probe channel.
    initial
    begin
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_results)
            begin
                result_ch.ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_results = 1'b0;
            end
            else
                result_ch.ready = !(result_gaps && $urandom_range(99) < 14);
        end
    end

    // Offer one probe item and hold it until the block takes it. Idle cycles
    // are inserted only before valid rises, never while an item is on offer.
    task automatic send_probe(tap_t tap, logic passed, logic sweep_end);
        @(negedge clk);
        while (probe_gaps && $urandom_range(99) < 14)
        begin
            probe_ch.valid = 1'b0;
            @(negedge clk);
        end
        probe_ch.valid     = 1'b1;
        probe_ch.tap       = tap;
        probe_ch.passed    = passed;
        probe_ch.sweep_end = sweep_end;
        @(posedge clk);
        while (!probe_ch.ready)
            @(posedge clk);
        probes_sent++;
        if (sweep_end)
            sweeps_sent++;
    endtask

    // Drop valid, wait for every predicted window to come back, then let the
    // pipeline settle so a register write cannot race a probe still inside.
    task automatic wait_idle();
        @(negedge clk);
        probe_ch.valid = 1'b0;
        while (windows_pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t index, logic [CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic apply_settings(search_mode_t mode, tap_t dflt, logic zero_dflt);
        write_reg(REG_SEARCH_MODE, CFG_DATA_BITS'(mode));
        write_reg(REG_DEFAULT_DELAY, dflt);
        write_reg(REG_ZERO_USES_DEFAULT, CFG_DATA_BITS'(zero_dflt));
        settings_used++;
    endtask

    // A realistic sweep: taps step by one from a start tap (now and then
    // downward, which makes runs whose stop lies below their start), with one
    // or two passing windows and a little flipped noise on top.
    task automatic send_tidy_sweep(int len);
        tap_t start_tap;
        bit   downward;
        int   win_a_lo;
        int   win_a_hi;
        int   win_b_lo;
        int   win_b_hi;
        logic passed;
        tap_t tap;
        start_tap = ($urandom_range(3) == 0) ? tap_t'($urandom) : '0;
        downward  = ($urandom_range(9) == 0);
        win_a_lo  = $urandom_range(len - 1);
        win_a_hi  = $urandom_range(len - 1, win_a_lo);
        win_b_lo  = $urandom_range(len - 1);
        win_b_hi  = $urandom_range(1) ? int'($urandom_range(len - 1, win_b_lo)) : -1;
        for (int i = 0; i < len; i++)
        begin
            passed = (i >= win_a_lo && i <= win_a_hi) || (i >= win_b_lo && i <= win_b_hi);
            if ($urandom_range(99) < 6)
                passed = !passed;
            tap = downward ? tap_t'(start_tap - i) : tap_t'(start_tap + i);
            send_probe(tap, passed, i == len - 1);
        end
    endtask

    // Junk sweep: random taps and random pass marks.
    task automatic send_noise_sweep(int len);
        for (int i = 0; i < len; i++)
            send_probe(tap_t'($urandom), logic'($urandom_range(1)), i == len - 1);
    endtask

    initial
    begin
        int phase;
        int phase_start;
        int random_start;
        int len;

        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        probe_ch.valid     = 1'b0;
        probe_ch.tap       = '0;
        probe_ch.passed    = 1'b0;
        probe_ch.sweep_end = 1'b0;
        probe_gaps         = 1'b1;
        result_gaps        = 1'b1;
        hold_results       = 1'b0;
        probes_sent        = 0;
        sweeps_sent        = 0;
        settings_used      = 1;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // ---------------- Directed sweeps, reset settings ----------------
        // Lone failing sweep end: no window, so the default delay comes back.
        send_probe(6'd5, 1'b0, 1'b1);

        // Run 0..1 is kept at first; the passing tap at 63 joins the run opened at 3,
        // so the run 3..63 is still open at the end, is closed there, replaces the
        // kept run and is wide.
        send_probe(6'd0, 1'b1, 1'b0);
        send_probe(6'd1, 1'b1, 1'b0);
        send_probe(6'd2, 1'b0, 1'b0);
        send_probe(6'd3, 1'b1, 1'b0);
        send_probe(6'd4, 1'b1, 1'b0);
        send_probe(6'd63, 1'b1, 1'b1);

        // A run that steps downward has a negative width and is never kept;
        // the run 20..27 open at the sweep end is closed, kept and is wide.
        send_probe(6'd40, 1'b1, 1'b0);
        send_probe(6'd33, 1'b1, 1'b0);
        send_probe(6'd10, 1'b0, 1'b0);
        send_probe(6'd20, 1'b1, 1'b0);
        send_probe(6'd27, 1'b1, 1'b1);

        // Zero midpoint with replacement on picks the default delay.
        wait_idle();
        apply_settings(MODE_WIDEST, 6'd63, 1'b1);
        send_probe(6'd0, 1'b1, 1'b0);
        send_probe(6'd1, 1'b1, 1'b1);

        // First mode keeps the single-tap run at 8 and ignores every probe
        // after it closes, except for the sweep end.
        wait_idle();
        apply_settings(MODE_FIRST, 6'd0, 1'b1);
        send_probe(6'd7, 1'b0, 1'b0);
        send_probe(6'd8, 1'b1, 1'b0);
        send_probe(6'd9, 1'b0, 1'b0);
        send_probe(6'd20, 1'b1, 1'b0);
        send_probe(6'd30, 1'b1, 1'b0);
        send_probe(6'd31, 1'b0, 1'b1);

        // Mode switched in the middle of a sweep: the run opened in first mode
        // is closed under the widest rule.
        send_probe(6'd10, 1'b1, 1'b0);
        send_probe(6'd12, 1'b1, 1'b0);
        wait_idle();
        write_reg(REG_SEARCH_MODE, CFG_DATA_BITS'(MODE_WIDEST));
        settings_used++;
        send_probe(6'd14, 1'b0, 1'b1);

        // ---------------- Random phases ----------------
        // Each phase picks new settings while the block is idle, then runs
        // sweeps. The first two phases use the default delay extremes; one
        // phase runs with no idling on either side; one phase holds results
        // back for a long stretch while short sweeps keep coming.
        random_start = probes_sent;
        phase = 0;
        while (probes_sent - random_start < RANDOM_ITEMS)
        begin
            wait_idle();
            case (phase)
                0:       apply_settings(MODE_WIDEST, 6'd0, 1'b1);
                1:       apply_settings(MODE_FIRST, 6'd63, 1'b0);
                default: apply_settings(search_mode_t'($urandom_range(1)),
                                        tap_t'($urandom), logic'($urandom_range(1)));
            endcase
            probe_gaps  = (phase != 2);
            result_gaps = (phase != 2);
            if (phase == 4)
                hold_results = 1'b1;

            phase_start = probes_sent;
            while (probes_sent - phase_start < PHASE_ITEMS)
            begin
                if (phase == 4)
                    send_tidy_sweep($urandom_range(1, 3));
                else if ($urandom_range(3) == 0)
                    send_noise_sweep($urandom_range(1, 12));
                else
                begin
                    len = ($urandom_range(19) == 0) ? 64 : int'($urandom_range(1, 20));
                    send_tidy_sweep(len);
                end
            end
            phase++;
        end

        wait_idle();

        $display("Sent %0d probe items in %0d sweeps under %0d register settings,",
                 probes_sent, sweeps_sent, settings_used);
        $display("both search modes, default delay 0 and 63, %0d results checked.",
                 results_seen);
        if (mismatches == 0)
            $display("delay_window_search: match");
        else
            $display("delay_window_search: mismatch");
        $finish;
    end

endmodule
